FILE: sv/bds_pkg.sv
`default_nettype none

package bds_pkg;

    // Geometry limits
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);

    // Field widths
    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int TOTAL_W    = PIX_W + 2;
    localparam int PIXEL_W    = PIX_W * MAX_CHANNELS;
    localparam int ENTRY_W    = SUM_W * MAX_CHANNELS;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CHCNT_W    = 3;
    localparam int COL_W      = LINE_AW + 1;
    localparam int ROW_W      = 12;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [CHCNT_W-1:0]  CHCNT_RESET  = CHCNT_W'(4);

    // Register index (byte address bits [3:2])
    typedef enum logic [1:0] {
        REG_SRC_WIDTH     = 2'd0,
        REG_SRC_HEIGHT    = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0]  src_width;
        logic [HEIGHT_W-1:0] src_height;
        logic [CHCNT_W-1:0]  channel_count;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/bds_line_ram.sv
`default_nettype none

module bds_line_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 36
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/bds_regs.sv
`default_nettype none

module bds_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bds_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bds_pkg::APB_DW-1:0]  pwdata,
    output logic      [bds_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output bds_pkg::cfg_t                    cfg
);

    import bds_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHCNT_W-1:0]  chcnt_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chcnt_reg  <= CHCNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SRC_WIDTH:     width_reg  <= pwdata[WIDTH_W-1:0];
                REG_SRC_HEIGHT:    height_reg <= pwdata[HEIGHT_W-1:0];
                REG_CHANNEL_COUNT: chcnt_reg  <= pwdata[CHCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            REG_SRC_WIDTH:     prdata = APB_DW'(width_reg);
            REG_SRC_HEIGHT:    prdata = APB_DW'(height_reg);
            REG_CHANNEL_COUNT: prdata = APB_DW'(chcnt_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.src_width     = width_reg;
    assign cfg.src_height    = height_reg;
    assign cfg.channel_count = chcnt_reg;

endmodule

`default_nettype wire

FILE: sv/box_downscale_2x.sv
// 2x2 box-filter downscaler for a raster pixel stream.
// Input channel: in_valid/in_ready with one source pixel (chan_a..chan_d)
// per item, in raster order. Output channel: out_valid/out_ready with one
// averaged pixel (out_a..out_d, row_end, frame_end) per item, produced on
// the odd column of every odd source row; output size is floor(W/2) x
// floor(H/2). Unused channels read zero.
// Configuration: APB port, src_width at 0x0, src_height at 0x4,
// channel_count at 0x8; write only while the stream is idle.
// Throughput: one source pixel per clock while in_ready is high. Even
// rows write horizontal pair sums into a 1024 x 36 line RAM; odd rows
// read the matching entry from the registered read port and add it to
// the current pair sum, which waits in the read stage meanwhile. The
// result moves into the output register once the output slot is free.
// Stall: the output register holds while out_ready is low, and the read
// stage while the output register is also full; in_ready drops only when
// both are full, so input keeps flowing as long as one slot is free.
// Reset: counters, left pixel and pipeline valids clear, registers return
// to 640 x 480 with four channels. The line RAM is not cleared; every
// entry is written on an even row before an odd row reads it.
`default_nettype none

module box_downscale_2x (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bds_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bds_pkg::APB_DW-1:0]  pwdata,
    output logic      [bds_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bds_pkg::PIX_W-1:0]   chan_a,
    input  wire logic [bds_pkg::PIX_W-1:0]   chan_b,
    input  wire logic [bds_pkg::PIX_W-1:0]   chan_c,
    input  wire logic [bds_pkg::PIX_W-1:0]   chan_d,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [bds_pkg::PIX_W-1:0]   out_a,
    output logic      [bds_pkg::PIX_W-1:0]   out_b,
    output logic      [bds_pkg::PIX_W-1:0]   out_c,
    output logic      [bds_pkg::PIX_W-1:0]   out_d,
    output logic                             row_end,
    output logic                             frame_end
);

    import bds_pkg::*;

    cfg_t                    cfg;
    logic [WIDTH_W-1:0]      eff_w;
    logic [HEIGHT_W-1:0]     eff_h;
    logic [WIDTH_W-1:0]      w_even;
    logic [HEIGHT_W-1:0]     h_even;

    logic                    accept;
    logic                    out_free;
    logic                    s1_adv;
    logic                    wr_en;
    logic                    rd_en;
    logic                    col_wrap;
    logic                    row_wrap;
    logic                    rend;
    logic                    fend;
    logic [LINE_AW-1:0]      line_idx;
    logic [PIXEL_W-1:0]      px;
    logic [ENTRY_W-1:0]      pair;
    logic [ENTRY_W-1:0]      line_rdata;
    logic [MAX_CHANNELS-1:0] mask;
    logic [PIXEL_W-1:0]      avg;

    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [PIXEL_W-1:0]      left_reg;

    logic                    s1_valid_reg;
    logic [ENTRY_W-1:0]      s1_pair_reg;
    logic [MAX_CHANNELS-1:0] s1_mask_reg;
    logic                    s1_rend_reg;
    logic                    s1_fend_reg;

    logic                    out_valid_reg;
    logic [PIXEL_W-1:0]      out_pix_reg;
    logic                    out_rend_reg;
    logic                    out_fend_reg;

    bds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp geometry to the supported range
    always_comb
    begin
        if (cfg.src_width == '0)
            eff_w = WIDTH_W'(1);
        else if (cfg.src_width > WIDTH_W'(MAX_WIDTH))
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = cfg.src_width;

        if (cfg.src_height == '0)
            eff_h = HEIGHT_W'(1);
        else if (cfg.src_height > HEIGHT_W'(HEIGHT_LIMIT))
            eff_h = HEIGHT_W'(HEIGHT_LIMIT);
        else
            eff_h = cfg.src_height;
    end

    assign w_even = {eff_w[WIDTH_W-1:1], 1'b0};
    assign h_even = {eff_h[HEIGHT_W-1:1], 1'b0};

    // Handshake: the read stage moves on when the output slot is free
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    assign px       = {chan_d, chan_c, chan_b, chan_a};
    assign line_idx = col_reg[COL_W-1:1];
    assign wr_en    = accept && col_reg[0] && !row_reg[0];
    assign rd_en    = accept && col_reg[0] && row_reg[0];

    // Horizontal pair sums and channel enables
    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            pair[c*SUM_W +: SUM_W] = SUM_W'(left_reg[c*PIX_W +: PIX_W])
                                   + SUM_W'(px[c*PIX_W +: PIX_W]);
            mask[c] = CHCNT_W'(c) < cfg.channel_count;
        end
    end

    // End-of-row / end-of-frame flags
    assign rend = (w_even != '0) && (WIDTH_W'(col_reg) == w_even - WIDTH_W'(1));
    assign fend = rend && (h_even != '0)
               && (HEIGHT_W'(row_reg) == h_even - HEIGHT_W'(1));

    // Column and row counters
    assign col_wrap = WIDTH_W'(col_reg) >= eff_w - WIDTH_W'(1);
    assign row_wrap = HEIGHT_W'(row_reg) >= eff_h - HEIGHT_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && !col_reg[0])
            begin
                left_reg <= px;
            end
        end
    end

    bds_line_ram #(
        .DEPTH (LINE_DEPTH),
        .DW    (ENTRY_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (line_idx),
        .wdata (pair),
        .re    (rd_en),
        .raddr (line_idx),
        .rdata (line_rdata)
    );

    // Read stage: holds the pair sum while the line entry is fetched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_pair_reg <= pair;
            s1_mask_reg <= mask;
            s1_rend_reg <= rend;
            s1_fend_reg <= fend;
        end
    end

    // Vertical add, divide by four, channel masking
    always_comb
    begin
        logic [TOTAL_W-1:0] tot;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            tot = TOTAL_W'(line_rdata[c*SUM_W +: SUM_W])
                + TOTAL_W'(s1_pair_reg[c*SUM_W +: SUM_W]);
            avg[c*PIX_W +: PIX_W] = s1_mask_reg[c] ? tot[TOTAL_W-1:2] : '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pix_reg  <= avg;
            out_rend_reg <= s1_rend_reg;
            out_fend_reg <= s1_fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = out_pix_reg[0*PIX_W +: PIX_W];
    assign out_b     = out_pix_reg[1*PIX_W +: PIX_W];
    assign out_c     = out_pix_reg[2*PIX_W +: PIX_W];
    assign out_d     = out_pix_reg[3*PIX_W +: PIX_W];
    assign row_end   = out_rend_reg;
    assign frame_end = out_fend_reg;

endmodule

`default_nettype wire

FILE: tb/box_downscale_2x_checker.sv
`timescale 1ns / 1ps

module box_downscale_2x_checker
    import bds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [PIX_W-1:0]    chan_a,
    input  logic [PIX_W-1:0]    chan_b,
    input  logic [PIX_W-1:0]    chan_c,
    input  logic [PIX_W-1:0]    chan_d,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [PIX_W-1:0]    out_a,
    input  logic [PIX_W-1:0]    out_b,
    input  logic [PIX_W-1:0]    out_c,
    input  logic [PIX_W-1:0]    out_d,
    input  logic                row_end,
    input  logic                frame_end,
    output int                  mismatches,
    output int                  owed
);

    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] d;
        logic             row_end;
        logic             frame_end;
    } out_px_t;

    // Expected output pixels, oldest first
    out_px_t owed_px[$];

    // Mirror of the configuration registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHCNT_W-1:0]  chcnt_reg;

    // Mirror of the datapath state
    logic [3:0][SUM_W-1:0] pair_line [LINE_DEPTH];
    logic [3:0][PIX_W-1:0] left_px;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;

    // Advance the raster position by one source pixel; queue an averaged
    // pixel when it closes a 2x2 block.
    task automatic average_block(input logic [3:0][PIX_W-1:0] px);
        int                    w;
        int                    h;
        int                    ch;
        int                    idx;
        int                    last_col;
        int                    last_row;
        logic [3:0][SUM_W-1:0] pair;
        logic [3:0][PIX_W-1:0] avg;
        logic [TOTAL_W-1:0]    total;
        out_px_t               r;
        w = int'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg);
        if (h == 0) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        ch = int'(chcnt_reg);
        if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;

        if (!col[0])
            left_px = px;
        else
        begin
            idx = int'(col >> 1);
            for (int c = 0; c < 4; c++)
                pair[c] = SUM_W'(left_px[c]) + SUM_W'(px[c]);
            if (!row[0])
                pair_line[idx] = pair;
            else
            begin
                last_col = (w & ~1) - 1;
                last_row = (h & ~1) - 1;
                for (int c = 0; c < 4; c++)
                begin
                    total  = TOTAL_W'(pair_line[idx][c]) + TOTAL_W'(pair[c]);
                    avg[c] = (c < ch) ? total[TOTAL_W-1:2] : '0;
                end
                r.a         = avg[0];
                r.b         = avg[1];
                r.c         = avg[2];
                r.d         = avg[3];
                r.row_end   = (w >= 2) && (int'(col) == last_col);
                r.frame_end = r.row_end && (h >= 2) && (int'(row) == last_row);
                owed_px.push_back(r);
            end
        end

        // counters wrap at (or past) the last position
        if (int'(col) >= w - 1)
        begin
            col = '0;
            if (int'(row) >= h - 1)
                row = '0;
            else
                row = row + 1'b1;
        end
        else
            col = col + 1'b1;
    endtask

    function automatic void check_field(string name, logic [PIX_W-1:0] want,
                                        logic [PIX_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_px_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            chcnt_reg  = CHCNT_RESET;
            left_px    = '0;
            col        = '0;
            row        = '0;
            mismatches = 0;
            owed_px.delete();
        end
        else
        begin
            // compare each delivered pixel with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (owed_px.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: output item with none expected, got %0d %0d %0d %0d %b %b",
                             $time, out_a, out_b, out_c, out_d, row_end, frame_end);
                end
                else
                begin
                    want = owed_px.pop_front();
                    check_field("out_a", want.a, out_a);
                    check_field("out_b", want.b, out_b);
                    check_field("out_c", want.c, out_c);
                    check_field("out_d", want.d, out_d);
                    check_field("row_end", PIX_W'(want.row_end), PIX_W'(row_end));
                    check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(frame_end));
                end
            end

            if (in_valid && in_ready)
                average_block({chan_d, chan_c, chan_b, chan_a});

            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SRC_WIDTH:     width_reg  = pwdata[WIDTH_W-1:0];
                    REG_SRC_HEIGHT:    height_reg = pwdata[HEIGHT_W-1:0];
                    REG_CHANNEL_COUNT: chcnt_reg  = pwdata[CHCNT_W-1:0];
                    default: ;
                endcase
            end
        end
        owed = owed_px.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bds_pkg::*;

    localparam int LIMIT = 2000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [PIX_W-1:0]    chan_a;
    logic [PIX_W-1:0]    chan_b;
    logic [PIX_W-1:0]    chan_c;
    logic [PIX_W-1:0]    chan_d;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PIX_W-1:0]    out_a;
    logic [PIX_W-1:0]    out_b;
    logic [PIX_W-1:0]    out_c;
    logic [PIX_W-1:0]    out_d;
    logic                row_end;
    logic                frame_end;

    int                  mismatches;
    int                  owed;
    int                  cycles = 0;
    int                  ready_run = 0;
    int                  gap_pct = 25;
    int                  fed = 0;
    bit                  calm = 1'b0;

    // 4x2 frame: saturated block, then a block that truncates to zero
    logic [31:0] corner_px [8] = '{
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0101_0101, 32'h0000_0000,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0101_0101, 32'h0100_0100
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    box_downscale_2x u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .chan_d    (chan_d),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .out_d     (out_d),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    box_downscale_2x_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .chan_a     (chan_a),
        .chan_b     (chan_b),
        .chan_c     (chan_c),
        .chan_d     (chan_d),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_a      (out_a),
        .out_b      (out_b),
        .out_c      (out_c),
        .out_d      (out_d),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .mismatches (mismatches),
        .owed       (owed)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output back-pressure: ready runs broken by random stall bursts
    always @(negedge clk)
    begin
        if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (calm || !out_ready)
        begin
            out_ready <= 1'b1;
            ready_run <= $urandom_range(1, 40);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_run <= $urandom_range(0, 7);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_pixel();
        return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int ch);
        apb_write(REG_SRC_WIDTH, APB_DW'(w));
        apb_write(REG_SRC_HEIGHT, APB_DW'(h));
        apb_write(REG_CHANNEL_COUNT, APB_DW'(ch));
    endtask

    // Present one pixel, with an occasional idle burst ahead of it
    task automatic send_pixel(input logic [31:0] px);
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        {chan_d, chan_c, chan_b, chan_a} <= px;
        do @(posedge clk); while (!in_ready);
        fed++;
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    // Drain: all predicted pixels out, then room for the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (owed != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int wr;
        int hr;
        int frames;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        chan_a    = '0;
        chan_b    = '0;
        chan_c    = '0;
        chan_d    = '0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full-scale and truncation on a 4x2 frame
        set_geometry(4, 2, 4);
        foreach (corner_px[i]) send_pixel(corner_px[i]);
        settle();

        // no active channels
        set_geometry(2, 2, 0);
        send_random(4);
        settle();

        // zero width and height act as one, channel count clamps to four
        set_geometry(0, 0, 7);
        send_random(3);
        settle();

        // trailing odd column and row are dropped
        set_geometry(3, 3, 2);
        send_random(9);
        settle();

        // width shrinks mid-row: column counter is past the end and wraps
        set_geometry(16, 4, 3);
        send_random(10);
        settle();
        apb_write(REG_SRC_WIDTH, APB_DW'(4));
        send_random(13);
        settle();

        // height shrinks mid-frame: row counter is past the end and wraps
        set_geometry(4, 8, 3);
        send_random(16);
        settle();
        apb_write(REG_SRC_HEIGHT, APB_DW'(2));
        send_random(4);
        settle();

        // all-ones width clamps to the maximum: part of a line, then the
        // width drops below the column counter, which wraps on the next item
        gap_pct = 10;
        set_geometry(4095, 2, 4);
        send_random(96);
        settle();
        apb_write(REG_SRC_WIDTH, APB_DW'(96));
        send_random(97);
        settle();

        // all-ones height clamps to the limit: a few rows, then the height
        // drops below the row counter, which wraps at the end of that row
        set_geometry(2, 8191, 1);
        send_random(2 * 20);
        settle();
        apb_write(REG_SRC_HEIGHT, APB_DW'(2));
        send_random(2);
        settle();

        // random geometry, a frame or two per setting
        while (fed < 1150)
        begin
            if ($urandom_range(7) == 0)
            begin
                wr = $urandom_range(33, 400);
                hr = 2;
            end
            else
            begin
                wr = $urandom_range(0, 32);
                hr = $urandom_range(0, 9);
            end
            frames = $urandom_range(1, 2);
            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 25;
                default: gap_pct = 50;
            endcase
            calm = (fed > 900);
            set_geometry(wr, hr, $urandom_range(0, 7));
            send_random((wr == 0 ? 1 : wr) * (hr == 0 ? 1 : hr) * frames);
            settle();
        end

        in_valid <= 1'b0;
        while (owed != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: box_downscale_2x.f
sv/bds_pkg.sv
sv/bds_line_ram.sv
sv/bds_regs.sv
sv/box_downscale_2x.sv
tb/box_downscale_2x_checker.sv
tb/tb.sv
